/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker module of this project.
// Every assertion samples on the rising clock edge and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property, reported with $error on failure.
`define WBBW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Hold check: once cond is seen, sig must be high in the following cycle.
`define WBBW_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    `WBBW_ASSERT(label, clk, rst_n, (cond) |=> (sig), msg)

`endif

/* hw/rtl/wbbw_pkg.sv */
// ----------------------------------------------------------------------------
// wbbw_pkg
// Shared types and constants for the windowed bark/bite watchdog.
// ----------------------------------------------------------------------------
package wbbw_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int KIND_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_PET     = 2'd1,
        KIND_ENABLE  = 2'd2,
        KIND_DISABLE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_EARLY    = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BARK   = 2'd0,
        CFG_BITE   = 2'd1,
        CFG_WINDOW = 2'd2
    } t_cfg_idx;

endpackage

/* hw/rtl/windowed_bark_bite_watchdog_unit.sv */
// ----------------------------------------------------------------------------
// windowed_bark_bite_watchdog_unit
// Windowed watchdog: saturating tick counter with bark and bite thresholds
// and an early-pet window. One result transaction per event transaction.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  event   | in        | i_valid / o_stall         | i_kind, i_sleeping
//  result  | out       | o_valid / i_stall         | o_status, o_count_now, o_bark,
//          |           |                           | o_bite, o_running
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  The watchdog state and the result are both registered at the accepting edge;
//  the result goes to the skid register while an untaken one sits in the output register.
//  Sustained rate is one event per clock while the result side does not stall.
//  A two-entry output buffer (output register plus skid register) lets the
//  block take an event while a result waits; o_stall rises only once both
//  entries are full, and it comes straight from the skid valid flag.
//  Synchronous active-low reset clears counter, flags, thresholds and buffer.
//  Configuration writes are always taken (o_cfg_ready is tied high).
// ----------------------------------------------------------------------------
module windowed_bark_bite_watchdog_unit
    import wbbw_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic                 i_sleeping,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [DATA_W-1:0]    o_count_now,
    output logic                 o_bark,
    output logic                 o_bite,
    output logic                 o_running,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    // Compare width covers both the counter and the 32-bit thresholds.
    localparam int CMP_W = (COUNT_WIDTH > DATA_W) ? COUNT_WIDTH : DATA_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   count_now;
        logic                bark;
        logic                bite;
        logic                running;
    } t_result;

    // configuration registers
    logic [DATA_W-1:0] r_bark_thr;
    logic [DATA_W-1:0] r_bite_thr;
    logic [DATA_W-1:0] r_window_min;

    // watchdog state
    logic [COUNT_WIDTH-1:0] r_counter, n_counter;
    logic                   r_enabled, n_enabled;
    logic                   r_bark,    n_bark;
    logic                   r_bite,    n_bite;

    // output buffer
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    t_result w_result;

    logic                   w_in_accept;
    logic                   w_out_take;
    logic [COUNT_WIDTH-1:0] w_tick_count;
    logic [CMP_W-1:0]       w_tick_ext;
    logic [CMP_W-1:0]       w_cur_ext;
    logic [DATA_W-1:0]      w_window;
    logic                   w_pet_early;
    t_status                w_status;

    // The block only stalls when both buffer entries hold results.
    assign o_stall     = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign w_in_accept = i_valid & ~r_skid_valid;
    assign w_out_take  = r_out_valid & ~i_stall;

    // Advance the counter unless asleep; hold at all ones.
    assign w_tick_count = (!i_sleeping && !(&r_counter)) ?
                          r_counter + COUNT_WIDTH'(1) : r_counter;
    assign w_tick_ext   = CMP_W'(w_tick_count);
    assign w_cur_ext    = CMP_W'(r_counter);

    // Effective window: clamp to half the bark threshold when the configured
    // minimum is not below a nonzero bark threshold.
    assign w_window = ((r_bark_thr != '0) && (r_window_min >= r_bark_thr)) ?
                      (r_bark_thr >> 1) : r_window_min;
    assign w_pet_early = (w_window != '0) && (w_cur_ext < CMP_W'(w_window));

    always_comb begin
        n_counter = r_counter;
        n_enabled = r_enabled;
        n_bark    = r_bark;
        n_bite    = r_bite;
        w_status  = ST_OK;
        case (t_kind'(i_kind))
            KIND_TICK: begin
                // Compare against the count after the advance, asleep or not.
                if (r_enabled) begin
                    n_counter = w_tick_count;
                    if (w_tick_ext >= CMP_W'(r_bark_thr)) begin
                        n_bark = 1'b1;
                    end
                    if (w_tick_ext >= CMP_W'(r_bite_thr)) begin
                        n_bite = 1'b1;
                    end
                end
            end
            KIND_PET: begin
                // Refused pets leave the state alone.
                if (!r_enabled) begin
                    w_status = ST_DISABLED;
                end else if (w_pet_early) begin
                    w_status = ST_EARLY;
                end else begin
                    n_counter = '0;
                    n_bark    = 1'b0;
                end
            end
            KIND_ENABLE: begin
                n_counter = '0;
                n_bark    = 1'b0;
                n_enabled = 1'b1;
            end
            default: begin
                // Disable: drop the enable flag only.
                n_enabled = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_result.status    = w_status;
        w_result.count_now = DATA_W'(n_counter);
        w_result.bark      = n_bark;
        w_result.bite      = n_bite;
        w_result.running   = n_enabled;
    end

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bark_thr   <= '0;
            r_bite_thr   <= '0;
            r_window_min <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BARK:   r_bark_thr   <= i_cfg_data;
                CFG_BITE:   r_bite_thr   <= i_cfg_data;
                CFG_WINDOW: r_window_min <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Watchdog state advances on every accepted event transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_enabled <= 1'b0;
            r_bark    <= 1'b0;
            r_bite    <= 1'b0;
        end else if (w_in_accept) begin
            r_counter <= n_counter;
            r_enabled <= n_enabled;
            r_bark    <= n_bark;
            r_bite    <= n_bite;
        end
    end

    // Output register plus skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // Refill the output register from the skid entry.
            if (w_out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_accept) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_in_accept) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out.status;
    assign o_count_now = r_out.count_now;
    assign o_bark      = r_out.bark;
    assign o_bite      = r_out.bite;
    assign o_running   = r_out.running;

endmodule

/* hw/rtl/wbbw_checker.sv */
// ----------------------------------------------------------------------------
// wbbw_checker
// Port-level assertions for the windowed bark/bite watchdog, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbbw_checker
    import wbbw_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic                o_bite,
    input logic                o_running
);

    // Remember a bite seen in a delivered result transaction.
    logic r_seen_bite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_bite <= 1'b0;
        end else if (o_valid && !i_stall && o_bite) begin
            r_seen_bite <= 1'b1;
        end
    end

    `WBBW_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")
    `WBBW_ASSERT(a_bite_sticky, i_clk, i_rst_n, o_valid && r_seen_bite |-> o_bite, "bite cleared after being raised")
    `WBBW_ASSERT(a_early_running, i_clk, i_rst_n, o_valid && (o_status == ST_EARLY) |-> o_running, "early pet reported while disabled")
    `WBBW_ASSERT(a_disabled_idle, i_clk, i_rst_n, o_valid && (o_status == ST_DISABLED) |-> !o_running, "disabled pet reported while running")

endmodule

bind windowed_bark_bite_watchdog_unit wbbw_checker u_wbbw_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_status  (o_status),
    .o_bite    (o_bite),
    .o_running (o_running)
);

/* tb/sv/windowed_bark_bite_watchdog_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_bark_bite_watchdog_unit_tb
// Self-checking bench for the windowed bark/bite watchdog. A directed table
// covers reset values, refused pets, the window clamp and the zero
// thresholds. Random phases follow, each with its own threshold and window
// setting. Each result is checked against a hand-written value or an in-bench
// model of the counter, flags and pet window. Both channels idle at random.
// ----------------------------------------------------------------------------
module windowed_bark_bite_watchdog_unit_tb;
    import wbbw_pkg::*;

    localparam int QUIET_LIMIT     = 1000;  // cycles with no transaction at all
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int SETTLE_CYCLES   = 8;

    // Index 3 maps to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] count;
        logic              bark;
        logic              bite;
        logic              running;
    } wd_result_t;

    // One line of the directed table: a register write or an event.
    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
        t_kind                kind;
        logic                 sleeping;
        logic                 typed;
        wd_result_t           want;
    } plan_row_t;

    // DUT ports
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [KIND_W-1:0]    i_kind      = KIND_TICK;
    logic                 i_sleeping  = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [DATA_W-1:0]    o_count_now;
    logic                 o_bark;
    logic                 o_bite;
    logic                 o_running;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_BARK;
    logic [DATA_W-1:0]    i_cfg_data  = '0;

    // Watchdog model state and its register copies
    logic [DATA_W-1:0] wd_count;
    logic              wd_enabled;
    logic              wd_bark;
    logic              wd_bite;
    logic [DATA_W-1:0] thr_bark;
    logic [DATA_W-1:0] thr_bite;
    logic [DATA_W-1:0] thr_window;

    wd_result_t expected_q[$];
    plan_row_t  plan[$];
    int         mismatches  = 0;
    int         quiet_cycles = 0;
    int         stall_left  = 0;
    int         free_left   = 0;
    bit         calm        = 1'b0;  // set for the final phase: no idling

    windowed_bark_bite_watchdog_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_sleeping  (i_sleeping),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_count_now (o_count_now),
        .o_bark      (o_bark),
        .o_bite      (o_bite),
        .o_running   (o_running),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Watchdog model
    // ------------------------------------------------------------------

    // Clamp the window to half the bark threshold once it reaches that
    // threshold; a zero bark threshold leaves the window as written.
    function automatic logic [DATA_W-1:0] pet_window();
        if (thr_bark != '0 && thr_window >= thr_bark) begin
            return thr_bark / 2;
        end
        return thr_window;
    endfunction

    // Apply one accepted event to the model and return the result it yields.
    function automatic wd_result_t advance_watchdog(t_kind k, logic s);
        wd_result_t       r;
        logic [DATA_W-1:0] win;
        r = '0;
        r.status = ST_OK;
        case (k)
            KIND_TICK: begin
                // Compare on every enabled tick, even asleep; saturate.
                if (wd_enabled) begin
                    if (!s && wd_count != '1) begin
                        wd_count = wd_count + 1'b1;
                    end
                    if (wd_count >= thr_bark) begin
                        wd_bark = 1'b1;
                    end
                    if (wd_count >= thr_bite) begin
                        wd_bite = 1'b1;
                    end
                end
            end
            KIND_PET: begin
                win = pet_window();
                if (!wd_enabled) begin
                    r.status = ST_DISABLED;
                end else if (win != '0 && wd_count < win) begin
                    r.status = ST_EARLY;
                end else begin
                    wd_count = '0;
                    wd_bark  = 1'b0;
                end
            end
            KIND_ENABLE: begin
                wd_count   = '0;
                wd_bark    = 1'b0;
                wd_enabled = 1'b1;
            end
            default: begin
                // Disable drops only the enable flag.
                wd_enabled = 1'b0;
            end
        endcase
        r.count   = wd_count;
        r.bark    = wd_bark;
        r.bite    = wd_bite;
        r.running = wd_enabled;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    function automatic plan_row_t cf(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        plan_row_t row;
        row = '{is_cfg: 1'b1, idx: idx, data: data, kind: KIND_TICK,
                sleeping: 1'b0, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic plan_row_t ev(t_kind k, logic s);
        plan_row_t row;
        row = '{is_cfg: 1'b0, idx: CFG_BARK, data: '0, kind: k,
                sleeping: s, typed: 1'b0, want: '0};
        return row;
    endfunction

    // Event whose result is written out by hand.
    function automatic plan_row_t evx(t_kind k, logic s, t_status st,
                                      logic [DATA_W-1:0] c, logic bk, logic bt,
                                      logic rn);
        plan_row_t row;
        row = ev(k, s);
        row.typed = 1'b1;
        row.want  = '{status: st, count: c, bark: bk, bite: bt, running: rn};
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Present one event and hold it until the block takes it; then queue
    // either the hand-written result or the model's.
    task automatic send_event(t_kind k, logic s, logic typed, wd_result_t want);
        wd_result_t pred;
        i_valid    <= 1'b1;
        i_kind     <= k;
        i_sleeping <= s;
        do @(posedge i_clk); while (o_stall);
        pred = advance_watchdog(k, s);
        expected_q.push_back(typed ? want : pred);
    endtask

    task automatic sender_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold the event channel idle until every result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Write one register, then leave the channel idle before returning.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BARK:   thr_bark   = data;
            CFG_BITE:   thr_bite   = data;
            CFG_WINDOW: thr_window = data;
            default:    ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: enable when stopped, then ticks with
    // pets mixed in, and now and then a re-enable, a disable or noise.
    task automatic pick_event(output t_kind k, output logic s);
        int r;
        r = $urandom_range(0, 99);
        s = ($urandom_range(0, 4) == 0);
        if (!wd_enabled) begin
            k = (r < 70) ? KIND_ENABLE : t_kind'($urandom_range(0, 3));
        end else if (r < 72) begin
            k = KIND_TICK;
        end else if (r < 88) begin
            k = KIND_PET;
        end else if (r < 94) begin
            k = KIND_ENABLE;
        end else begin
            k = KIND_DISABLE;
        end
    endtask

    task automatic log_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, then the checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (calm) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            i_stall <= 1'b0;
            free_left--;
        end else begin
            i_stall <= 1'b0;
            // Mostly short free runs, sometimes a long one with no stall.
            free_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 30);
            stall_left = $urandom_range(1, 12);
        end
    end

    always @(posedge i_clk) begin : result_check
        wd_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                log_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_q.pop_front();
                if (o_status !== want.status) begin
                    log_mismatch($sformatf("status got %0d want %0d", o_status, want.status));
                end
                if (o_count_now !== want.count) begin
                    log_mismatch($sformatf("count_now got %0d want %0d",
                                           o_count_now, want.count));
                end
                if (o_bark !== want.bark) begin
                    log_mismatch($sformatf("bark got %b want %b", o_bark, want.bark));
                end
                if (o_bite !== want.bite) begin
                    log_mismatch($sformatf("bite got %b want %b", o_bite, want.bite));
                end
                if (o_running !== want.running) begin
                    log_mismatch($sformatf("running got %b want %b",
                                           o_running, want.running));
                end
            end
        end
    end

    // Give up when no transaction moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_kind             k;
        logic              s;
        logic [DATA_W-1:0] bark;
        logic [DATA_W-1:0] bite;
        logic [DATA_W-1:0] win;
        int                p;
        int                n;

        wd_count   = '0;
        wd_enabled = 1'b0;
        wd_bark    = 1'b0;
        wd_bite    = 1'b0;
        thr_bark   = '0;
        thr_bite   = '0;
        thr_window = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Keep bite out of reach here: it is sticky for the rest of the run.
        plan.push_back(cf(CFG_BITE, '1));
        plan.push_back(cf(CFG_SPARE, '1));
        // Everything refused or idle straight out of reset, then an enable.
        plan.push_back(evx(KIND_TICK,    1'b0, ST_OK,       0, 1'b0, 1'b0, 1'b0));
        plan.push_back(evx(KIND_PET,     1'b0, ST_DISABLED, 0, 1'b0, 1'b0, 1'b0));
        plan.push_back(evx(KIND_DISABLE, 1'b1, ST_OK,       0, 1'b0, 1'b0, 1'b0));
        plan.push_back(evx(KIND_ENABLE,  1'b1, ST_OK,       0, 1'b0, 1'b0, 1'b1));
        // Zero bark threshold fires on the first tick, asleep or not.
        plan.push_back(evx(KIND_TICK,    1'b1, ST_OK,       0, 1'b1, 1'b0, 1'b1));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(ev(KIND_PET, 1'b0));
        plan.push_back(ev(KIND_TICK, 1'b0));
        // Disable holds count and bark; ticks then do nothing.
        plan.push_back(ev(KIND_DISABLE, 1'b0));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(evx(KIND_PET,     1'b1, ST_DISABLED, 1, 1'b1, 1'b0, 1'b0));
        plan.push_back(ev(KIND_ENABLE, 1'b0));
        // Plain window below the bark threshold.
        plan.push_back(cf(CFG_BARK, 3));
        plan.push_back(cf(CFG_WINDOW, 2));
        plan.push_back(evx(KIND_PET,     1'b0, ST_EARLY,    0, 1'b0, 1'b0, 1'b1));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(ev(KIND_PET, 1'b0));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(ev(KIND_TICK, 1'b0));
        // Re-enable while running clears count and bark.
        plan.push_back(ev(KIND_ENABLE, 1'b0));
        // Window at or above bark: clamped to half of bark.
        plan.push_back(cf(CFG_WINDOW, '1));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(evx(KIND_PET,     1'b0, ST_OK,       0, 1'b0, 1'b0, 1'b1));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(ev(KIND_PET, 1'b0));
        plan.push_back(cf(CFG_BARK, '1));
        plan.push_back(ev(KIND_TICK, 1'b0));
        plan.push_back(evx(KIND_PET,     1'b0, ST_EARLY,    1, 1'b0, 1'b0, 1'b1));
        plan.push_back(ev(KIND_DISABLE, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_results();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_event(plan[i].kind, plan[i].sleeping, plan[i].typed, plan[i].want);
            end
        end

        // Random phases, each with a fresh setting; the last two bring the
        // bite threshold within reach.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    bark = '1;
                    win  = '1;
                end
                1: begin
                    bark = '0;
                    win  = '0;
                end
                default: begin
                    bark = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 12);
                    case ($urandom_range(0, 3))
                        0:       win = '0;
                        1:       win = $urandom_range(1, 10);
                        2:       win = bark;
                        default: win = $urandom;
                    endcase
                end
            endcase
            bite = (p >= PHASES - 2) ? $urandom_range(6, 40) : '1;

            // Pause the sender until every result is back before writing.
            drain_results();
            write_reg(CFG_BARK, bark);
            write_reg(CFG_BITE, bite);
            write_reg(CFG_WINDOW, win);
            if (p == PHASES - 1) begin
                calm = 1'b1;
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    sender_gap($urandom_range(1, 12));
                end
                pick_event(k, s);
                send_event(k, s, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* windowed_bark_bite_watchdog_unit.f */
+incdir+hw/rtl
hw/rtl/wbbw_pkg.sv
hw/rtl/windowed_bark_bite_watchdog_unit.sv
hw/rtl/wbbw_checker.sv
tb/sv/windowed_bark_bite_watchdog_unit_tb.sv
